>>> design/vigb36_pkg.sv
// Shared constants, types and character mapping functions for the base-36 Vigenere encryptor.
package vigb36_pkg;

    localparam int unsigned KEY_W      = 60;
    localparam int unsigned SYM_W      = 6;
    localparam int unsigned KEY_SLOTS  = KEY_W / SYM_W;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned OUT_CHAR_W = 7;
    localparam int unsigned KEY_MAX_DEF = 10;

    localparam logic [SYM_W-1:0] SYM_MAX     = 6'd35;
    localparam logic [SYM_W:0]   ALPHA_SIZE  = 7'd36;
    localparam logic [SYM_W-1:0] DIGIT_COUNT = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] LETTER_BIAS  = 8'd55;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    // Configuration register indexes
    localparam logic CFG_KEY_SYMBOLS = 1'b0;
    localparam logic CFG_KEY_LENGTH  = 1'b1;

    typedef struct packed {
        logic             keep;
        logic [SYM_W-1:0] sym;
    } t_sym;

    // ASCII to symbol value; keep is low for anything not alphanumeric.
    function automatic t_sym char_to_sym(input logic [CHAR_W-1:0] c);
        t_sym             r;
        logic [CHAR_W-1:0] u;
        logic [CHAR_W-1:0] d;
        r = '0;
        u = c;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            u = c - CASE_OFFSET;
        end
        if (u >= ASCII_UPPER_A && u <= ASCII_UPPER_Z) begin
            d      = u - LETTER_BIAS;
            r.keep = 1'b1;
            r.sym  = d[SYM_W-1:0];
        end else if (u >= ASCII_ZERO && u <= ASCII_NINE) begin
            d      = u - ASCII_ZERO;
            r.keep = 1'b1;
            r.sym  = d[SYM_W-1:0];
        end
        return r;
    endfunction

    // Symbol value 0..35 to ASCII digit or upper-case letter.
    function automatic logic [OUT_CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] s);
        logic [CHAR_W-1:0] c;
        if (s < DIGIT_COUNT) begin
            c = {2'b00, s} + ASCII_ZERO;
        end else begin
            c = {2'b00, s} + LETTER_BIAS;
        end
        return c[OUT_CHAR_W-1:0];
    endfunction

endpackage

>>> design/vigb36_keysel.sv
// Key position counter and key symbol selection.
module vigb36_keysel #(
    parameter int unsigned KEY_MAX = vigb36_pkg::KEY_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  logic                               i_restart,
    input  logic                               i_keep,
    input  logic [vigb36_pkg::KEY_W-1:0]       i_key_symbols,
    input  logic [vigb36_pkg::LEN_W-1:0]       i_key_length,
    output logic [vigb36_pkg::SYM_W-1:0]       o_key_sym
);

    localparam logic [vigb36_pkg::LEN_W-1:0] LEN_MAX = vigb36_pkg::LEN_W'(KEY_MAX);

    logic [vigb36_pkg::POS_W-1:0] r_pos;
    logic [vigb36_pkg::POS_W-1:0] n_pos;
    logic [vigb36_pkg::POS_W-1:0] pos_use;
    logic [vigb36_pkg::POS_W-1:0] pos_inc;
    logic [vigb36_pkg::LEN_W-1:0] len_eff;
    logic [vigb36_pkg::SYM_W-1:0] slot [vigb36_pkg::KEY_SLOTS];
    logic [vigb36_pkg::SYM_W-1:0] raw_sym;

    always_comb begin
        for (int i = 0; i < vigb36_pkg::KEY_SLOTS; i++) begin
            slot[i] = i_key_symbols[i*vigb36_pkg::SYM_W +: vigb36_pkg::SYM_W];
        end
    end

    always_comb begin
        len_eff = i_key_length;
        if (len_eff == '0) begin
            len_eff = vigb36_pkg::LEN_W'(1);
        end
        if (len_eff > LEN_MAX) begin
            len_eff = LEN_MAX;
        end
    end

    // Length may have been lowered since the last step: fall back to 0.
    always_comb begin
        pos_use = r_pos;
        if (i_restart || r_pos >= len_eff) begin
            pos_use = '0;
        end
        pos_inc = pos_use + vigb36_pkg::POS_W'(1);
        if (pos_inc >= len_eff) begin
            pos_inc = '0;
        end
        n_pos = i_keep ? pos_inc : pos_use;
    end

    // pos_use is always below len_eff, which never exceeds KEY_MAX (the slot count by default)
    assign raw_sym   = slot[pos_use];
    assign o_key_sym = (raw_sym > vigb36_pkg::SYM_MAX) ? vigb36_pkg::SYM_MAX : raw_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

endmodule

>>> design/vigb36_outreg.sv
// Modular add and result register on the master side.
module vigb36_outreg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [vigb36_pkg::SYM_W-1:0]        i_sym,
    input  logic [vigb36_pkg::SYM_W-1:0]        i_key_sym,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [vigb36_pkg::OUT_CHAR_W-1:0]   o_char
);

    logic                                r_valid;
    logic [vigb36_pkg::OUT_CHAR_W-1:0]   r_char;
    logic [vigb36_pkg::SYM_W:0]          sum;
    logic [vigb36_pkg::SYM_W:0]          sum_mod;

    // Both operands are at most 35, so one conditional subtract wraps it.
    always_comb begin
        sum     = {1'b0, i_sym} + {1'b0, i_key_sym};
        sum_mod = (sum >= vigb36_pkg::ALPHA_SIZE) ? sum - vigb36_pkg::ALPHA_SIZE : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= vigb36_pkg::sym_to_char(sum_mod[vigb36_pkg::SYM_W-1:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

>>> design/vigenere_encrypt_base36.sv
// Top level of the streaming base-36 Vigenere encryptor.
//
// Slave stream: one ASCII character per transaction in tdata, tuser set on
// the first character of a message to restart the key at symbol 0.
// Master stream: one ciphertext character ('0'-'9', 'A'-'Z') per kept input.
// Characters that are not letters or digits produce no output transaction.
// A character accepted at one edge shows on the master side after that edge.
// While the receiver is ready, one character per cycle is sustained; the
// single output register is reloaded in the same cycle it is drained. When
// the receiver stalls with a result held, o_s_tready drops until the result
// is taken, so nothing is lost or duplicated. Configuration (key symbols,
// key length) must be written through the plain write port while the stream
// is idle; the block does not enforce this. Reset clears the key to all zero
// symbols, the key length to 1, the key position to 0 and the output valid.
module vigenere_encrypt_base36 #(
    parameter int unsigned KEY_MAX = vigb36_pkg::KEY_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] text_char
    input  logic                               i_s_tuser,   // [0] message_start
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // [6:0] cipher_char, [7] zero
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [vigb36_pkg::KEY_W-1:0]       i_cfg_data
);

    logic [vigb36_pkg::KEY_W-1:0]       r_key_symbols;
    logic [vigb36_pkg::LEN_W-1:0]       r_key_length;
    logic                               accept;
    logic                               load;
    vigb36_pkg::t_sym                   in_sym;
    logic [vigb36_pkg::SYM_W-1:0]       key_sym;
    logic [vigb36_pkg::OUT_CHAR_W-1:0]  out_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_symbols <= '0;
            r_key_length  <= vigb36_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vigb36_pkg::CFG_KEY_SYMBOLS: r_key_symbols <= i_cfg_data;
                vigb36_pkg::CFG_KEY_LENGTH:
                    r_key_length <= i_cfg_data[vigb36_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_sym     = vigb36_pkg::char_to_sym(i_s_tdata);
    assign load       = accept && in_sym.keep;

    vigb36_keysel #(
        .KEY_MAX (KEY_MAX)
    ) u_keysel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_restart     (i_s_tuser),
        .i_keep        (in_sym.keep),
        .i_key_symbols (r_key_symbols),
        .i_key_length  (r_key_length),
        .o_key_sym     (key_sym)
    );

    vigb36_outreg u_outreg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_sym     (in_sym.sym),
        .i_key_sym (key_sym),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_char    (out_char)
    );

    assign o_m_tdata = {1'b0, out_char};

endmodule

>>> test/tb.sv
// Self-checking testbench for the streaming base-36 Vigenere encryptor.
`timescale 1ns / 1ps

module tb;
    import vigb36_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_AT     = 400;   // accepted chars before the long stall
    localparam int unsigned HOLD_LEN    = 160;

    typedef struct packed {
        logic             start;
        logic [CHAR_W-1:0] ch;
    } t_text_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata = '0;   // [7:0] text_char
    logic              i_s_tuser = 1'b0; // [0] message_start
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [7:0]        o_m_tdata;        // [6:0] cipher_char, [7] zero
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = CFG_KEY_SYMBOLS;
    logic [KEY_W-1:0]  i_cfg_data = '0;

    vigenere_encrypt_base36 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: mirrors the key registers and the key position.
    logic [KEY_W-1:0] key_sym_q = '0;
    logic [LEN_W-1:0] key_len_q = 4'd1;
    logic [POS_W-1:0] key_pos   = '0;

    t_text_item       char_q[$];     // plaintext waiting to be offered
    logic [6:0]       cipher_q[$];   // expected ciphertext, oldest first

    int unsigned n_accepted  = 0;
    int unsigned n_kept      = 0;
    int unsigned n_received  = 0;
    int unsigned n_cfg_write = 0;
    int unsigned err_count   = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned src_gap     = 0;
    int unsigned snk_gap     = 0;
    int          hold_left   = -1;
    logic        rx_hold     = 1'b0;
    logic        idle_en     = 1'b1;
    t_text_item  drv_item;
    logic [7:0]  want_char;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR @%0t: %s (got 0x%02h, expected 0x%02h)", $time, what, got, want);
        err_count++;
    endtask

    // Encrypts one accepted character and queues the result, if any.
    task automatic encrypt_char(input logic [CHAR_W-1:0] ch, input logic restart);
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] up;
        logic [SYM_W-1:0]  val;
        logic [SYM_W-1:0]  ks;
        logic [6:0]        total;
        logic              keep;
        len = key_len_q;
        if (len == 0) len = 4'd1;
        else if (len > 4'(KEY_MAX_DEF)) len = 4'(KEY_MAX_DEF);
        if (restart) key_pos = '0;
        if (key_pos >= len) key_pos = '0;   // length lowered under a live position
        up   = ch;
        keep = 1'b1;
        val  = '0;
        if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) up = ch - CASE_OFFSET;
        if (up >= ASCII_UPPER_A && up <= ASCII_UPPER_Z) val = 6'(up - LETTER_BIAS);
        else if (up >= ASCII_ZERO && up <= ASCII_NINE) val = 6'(up - ASCII_ZERO);
        else keep = 1'b0;
        if (keep) begin
            ks = key_sym_q[int'(key_pos) * SYM_W +: SYM_W];
            if (ks > SYM_MAX) ks = SYM_MAX;
            total = (7'(val) + 7'(ks)) % 7'd36;
            cipher_q.insert(cipher_q.size(),
                            total < 7'd10 ? 7'(total + 7'd48) : 7'(total + 7'd55));
            key_pos = key_pos + 1'b1;
            if (key_pos >= len) key_pos = '0;
            n_kept++;
        end
    endtask

    // Driver: offers queued characters, holds them through backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                encrypt_char(i_s_tdata, i_s_tuser);
                n_accepted++;
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    drv_item = char_q.pop_front();
                    i_s_tdata  <= drv_item.ch;
                    i_s_tuser  <= drv_item.start;
                    i_s_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver stall once traffic is flowing, so the input side backs up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left < 0 && n_accepted >= HOLD_AT) hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                rx_hold <= 1'b1;
            end else begin
                rx_hold <= 1'b0;
            end
        end
    end

    // Receiver ready with random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold) begin
            i_m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (idle_en && $urandom_range(0, 6) == 0) snk_gap = $urandom_range(1, 9);
        end
    end

    // Monitor: compares each output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_received++;
            if (cipher_q.size() == 0) begin
                report_mismatch("cipher_char with nothing expected", o_m_tdata, 8'h00);
            end else begin
                want_char = {1'b0, cipher_q.pop_front()};
                if (o_m_tdata !== want_char)
                    report_mismatch("cipher_char mismatch", o_m_tdata, want_char);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, cipher_q.size());
            $display("vigenere_encrypt_base36 test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [KEY_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_KEY_SYMBOLS) key_sym_q = value;
        else key_len_q = value[LEN_W-1:0];
        n_cfg_write++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Checked at the falling edge so queue and valid have settled.
    task automatic wait_stream_idle();
        do @(negedge i_clk);
        while (char_q.size() != 0 || i_s_tvalid || cipher_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic push_char(input logic [7:0] ch, input logic start);
        t_text_item it;
        it.ch    = ch;
        it.start = start;
        char_q.insert(char_q.size(), it);
    endtask

    initial begin
        int unsigned      ph;
        int unsigned      k;
        int unsigned      r;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] len_word;
        logic [7:0]       ch;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key is all zero: kept characters come out folded, unchanged.
        push_char(ASCII_ZERO, 1'b1);
        push_char(ASCII_NINE, 1'b0);
        push_char(ASCII_UPPER_A, 1'b0);
        push_char(ASCII_UPPER_Z, 1'b0);
        push_char(ASCII_LOWER_A, 1'b0);
        push_char(ASCII_LOWER_Z, 1'b0);
        push_char(8'h2F, 1'b0);   // neighbors of each range are dropped
        push_char(8'h3A, 1'b0);
        push_char(8'h40, 1'b0);
        push_char(8'h5B, 1'b0);
        push_char(8'h60, 1'b0);
        push_char(8'h7B, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'hC1, 1'b0);   // 'A' with the top bit set
        wait_stream_idle();

        // All key symbols 63 clamp to 35; length 15 behaves as 10.
        write_reg(CFG_KEY_SYMBOLS, '1);
        write_reg(CFG_KEY_LENGTH, '1);
        push_char(ASCII_UPPER_Z, 1'b1);
        push_char(ASCII_ZERO, 1'b0);
        push_char(8'h23, 1'b1);   // dropped, but still restarts the key
        push_char(ASCII_NINE, 1'b0);
        push_char(ASCII_LOWER_Z, 1'b0);
        wait_stream_idle();

        // Length zero behaves as one; mixed symbols around the wrap point.
        write_reg(CFG_KEY_SYMBOLS, {48'h0, 6'd1, 6'd35});
        write_reg(CFG_KEY_LENGTH, '0);
        push_char(ASCII_UPPER_A, 1'b0);
        push_char(ASCII_NINE, 1'b1);
        push_char(ASCII_LOWER_Z, 1'b0);
        wait_stream_idle();

        for (ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 0) begin
                key = KEY_W'({$urandom(), $urandom()});
            end else begin
                for (k = 0; k < KEY_SLOTS; k++)
                    key[k * SYM_W +: SYM_W] = SYM_W'($urandom_range(0, 35));
            end
            len_word = KEY_W'({$urandom(), $urandom()});
            case (ph)
                0: len_word[3:0] = 4'd10;
                1: len_word[3:0] = 4'd1;
                2: len_word[3:0] = 4'd0;
                3: len_word[3:0] = 4'd15;
                default: len_word[3:0] = 4'($urandom_range(1, 10));
            endcase
            if ($urandom_range(0, 1) == 0) len_word[KEY_W-1:4] = '0;
            if (ph == 7) idle_en <= 1'b0;
            write_reg(CFG_KEY_SYMBOLS, key);
            write_reg(CFG_KEY_LENGTH, len_word);
            for (k = 0; k < 141; k++) begin
                r = $urandom_range(0, 99);
                if (r < 35) ch = ASCII_UPPER_A + 8'($urandom_range(0, 25));
                else if (r < 60) ch = ASCII_LOWER_A + 8'($urandom_range(0, 25));
                else if (r < 85) ch = ASCII_ZERO + 8'($urandom_range(0, 9));
                else ch = 8'($urandom_range(0, 255));
                push_char(ch, $urandom_range(0, 11) == 0);
            end
            wait_stream_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("run: %0d characters accepted, %0d encrypted, %0d results checked",
                 n_accepted, n_kept, n_received);
        $display("run: %0d key register writes over 11 key settings", n_cfg_write);
        if (err_count == 0 && cipher_q.size() == 0) begin
            $display("vigenere_encrypt_base36 test passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", err_count, cipher_q.size());
            $display("vigenere_encrypt_base36 test failed");
        end
        $finish;
    end

endmodule
